### hdl/cycle_steal_admission_throttle_top_macros.svh
// Assertion macros used by the port checker of the admission throttle.
`ifndef CYCLE_STEAL_ADMISSION_THROTTLE_TOP_MACROS_SVH
`define CYCLE_STEAL_ADMISSION_THROTTLE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CST_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/cst_pkg.sv
// Shared types and constants of the cycle-steal admission throttle.
package cst_pkg;

  // Default depth of the core word memory.
  localparam int CORE_DEPTH_DFLT = 2048;

  // Field widths.
  localparam int WORD_W  = 15;
  localparam int TOKEN_W = 16;
  localparam int CNT_W   = 32;
  localparam int WIN_W   = 8;
  localparam int WSC_W   = 16;
  localparam int NUM_W   = 23;   // window steals times the percent scale
  localparam int PROD_W  = 40;   // elapsed cycles times refill rate
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Arithmetic constants of the load window and the alarm.
  localparam int PCT_SCALE     = 100;
  localparam int WIN_MAX       = 200;
  localparam int ALARM_MIN_WIN = 50;
  localparam int ALARM_PCT     = 55;
  localparam int INIT_WORDS    = 64;
  localparam logic [WORD_W-1:0] INIT_BASE = 15'h1000;

  // Action codes of an input request.
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_STEAL = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RUN_ENABLE   = 3'd0,
    CFG_STEAL_ENABLE = 3'd1,
    CFG_TOKEN_CAP    = 3'd2,
    CFG_REFILL       = 3'd3,
    CFG_PRIO_MASK    = 3'd4,
    CFG_SOFT_LIMIT   = 3'd5,
    CFG_HARD_LIMIT   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                run_enable;
    logic                steal_enable;
    logic [TOKEN_W-1:0]  token_capacity;
    logic [7:0]          refill_per_cycle;
    logic [7:0]          priority_allow_mask;
    logic [7:0]          soft_limit_pct;
    logic [7:0]          hard_limit_pct;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    run_enable:          1'b1,
    steal_enable:        1'b1,
    token_capacity:      16'd32,
    refill_per_cycle:    8'd4,
    priority_allow_mask: 8'h21,
    soft_limit_pct:      8'd25,
    hard_limit_pct:      8'd40
  };

  localparam logic [TOKEN_W-1:0] TOKEN_RESET = 16'd32;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Control strobes from the sequencer to the datapath.
  typedef struct packed {
    logic clear_we;
    logic take;
    logic exec;
  } ctl_t;

endpackage

### hdl/cst_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module cst_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/cst_ctrl.sv
// Sequencer: memory clearing sweep after reset, then take and execute one request.
module cst_ctrl #(
  parameter int CORE_DEPTH = cst_pkg::CORE_DEPTH_DFLT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          slot_free,
  output logic                          in_ready,
  output cst_pkg::ctl_t                 ctl,
  output logic [$clog2(CORE_DEPTH)-1:0] clr_addr
);

  localparam int AW = $clog2(CORE_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CORE_DEPTH - 1);

  cst_pkg::state_e state_r, state_nxt;
  logic [AW-1:0]   clr_addr_r, clr_addr_nxt;

  // State and sweep address registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cst_pkg::ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    unique case (state_r)
      cst_pkg::ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = cst_pkg::ST_IDLE;
        end
      end
      cst_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = cst_pkg::ST_EXEC;
        end
      end
      cst_pkg::ST_EXEC: begin
        if (slot_free) begin
          state_nxt = cst_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cst_pkg::ST_CLEAR;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready     = 1'b0;
    ctl.clear_we = 1'b0;
    ctl.take     = 1'b0;
    ctl.exec     = 1'b0;
    unique case (state_r)
      cst_pkg::ST_CLEAR: ctl.clear_we = 1'b1;
      cst_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ctl.take = in_valid;
      end
      cst_pkg::ST_EXEC: ctl.exec = slot_free;
      default: ;
    endcase
  end

  assign clr_addr = clr_addr_r;

endmodule

### hdl/cst_engine.sv
// Datapath: token bucket, load window, counters, core word update and result register.
module cst_engine #(
  parameter int CORE_DEPTH = cst_pkg::CORE_DEPTH_DFLT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cst_pkg::ctl_t                 ctl,
  input  cst_pkg::cfg_t                 cfg,
  input  logic                          in_action,
  input  logic [2:0]                    in_priority_req,
  input  logic [15:0]                   in_target_address,
  input  logic signed [15:0]            in_increment,
  input  logic [cst_pkg::WORD_W-1:0]    mem_rdata,
  output logic                          mem_we,
  output logic [$clog2(CORE_DEPTH)-1:0] mem_waddr,
  output logic [cst_pkg::WORD_W-1:0]    mem_wdata,
  output logic                          slot_free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_accepted,
  output logic                          out_overload_alarm,
  output logic [15:0]                   out_tokens_left,
  output logic [14:0]                   out_counter_value,
  output logic [31:0]                   out_steals_accepted,
  output logic [31:0]                   out_steals_dropped
);

  localparam int AW     = $clog2(CORE_DEPTH);
  localparam int NUM_W  = cst_pkg::NUM_W;
  localparam int TOK_W  = cst_pkg::TOKEN_W;
  localparam int PROD_W = cst_pkg::PROD_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic [16:0] DEPTH_LIM = 17'(CORE_DEPTH);

  // Persistent scalar state.
  logic [TOK_W-1:0]            tok_r, tok_nxt;
  logic [31:0]                 elapsed_r, elapsed_nxt;
  logic [cst_pkg::WIN_W-1:0]   wlen_r, wlen_nxt;
  logic [cst_pkg::WSC_W-1:0]   wsc_r, wsc_nxt;
  logic [31:0]                 acc_tot_r, acc_tot_nxt;
  logic [31:0]                 drop_tot_r, drop_tot_nxt;
  logic                        alarm_r, alarm_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // Request captured at take time, with precomputed products and compares.
  logic                        it_tick_r, it_steal_r;
  logic [15:0]                 it_addr_r;
  logic [cst_pkg::WORD_W-1:0]  it_inc_r;
  logic [PROD_W-1:0]           prod_r;
  logic                        hard_r, soft_r, mask_r, prio0_r, alarm_hit_r;

  // Result register.
  logic                        res_acc_r, res_alarm_r;
  logic [TOK_W-1:0]            res_tok_r;
  logic [cst_pkg::WORD_W-1:0]  res_val_r;
  logic [31:0]                 res_acc_tot_r, res_drop_tot_r;

  // Take-time signals.
  logic [cst_pkg::WSC_W-1:0]   wsc_inc;
  logic [NUM_W-1:0]            num_now, num_inc;
  logic [15:0]                 hard_prod, soft_prod, alarm_prod;
  logic                        hard_hit, soft_hit, alarm_hit;

  // Execute-time signals.
  logic [SUM_W-1:0]            refill_sum;
  logic [TOK_W-1:0]            tok_ref;
  logic                        admit, in_range;
  logic [cst_pkg::WIN_W:0]     wlen_inc;
  logic [cst_pkg::WORD_W-1:0]  word_sum;

  // Load tests without division: load >= L  is  steals * 100 >= L * window.
  always_comb begin
    wsc_inc    = (wsc_r == '1) ? wsc_r : wsc_r + 16'd1;
    num_now    = NUM_W'(wsc_r) * NUM_W'(cst_pkg::PCT_SCALE);
    num_inc    = NUM_W'(wsc_inc) * NUM_W'(cst_pkg::PCT_SCALE);
    hard_prod  = 16'(cfg.hard_limit_pct) * 16'(wlen_r);
    soft_prod  = 16'(cfg.soft_limit_pct) * 16'(wlen_r);
    alarm_prod = 16'(cst_pkg::ALARM_PCT + 1) * 16'(wlen_r);
    if (wlen_r == '0) begin
      hard_hit = (cfg.hard_limit_pct == 8'd0);
      soft_hit = (cfg.soft_limit_pct == 8'd0);
    end else begin
      hard_hit = (num_now >= NUM_W'(hard_prod));
      soft_hit = (num_now >= NUM_W'(soft_prod));
    end
    // Alarm test uses the window count as it stands after an admitted steal.
    alarm_hit = (wlen_r > cst_pkg::WIN_W'(cst_pkg::ALARM_MIN_WIN)) &&
                (num_inc >= NUM_W'(alarm_prod));
  end

  // Capture the request and its precomputed terms.
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      it_tick_r   <= (in_action == cst_pkg::ACT_TICK) && cfg.run_enable;
      it_steal_r  <= (in_action == cst_pkg::ACT_STEAL) && cfg.run_enable &&
                     cfg.steal_enable;
      it_addr_r   <= in_target_address;
      it_inc_r    <= in_increment[cst_pkg::WORD_W-1:0];
      prod_r      <= PROD_W'(elapsed_r) * PROD_W'(cfg.refill_per_cycle);
      hard_r      <= hard_hit;
      soft_r      <= soft_hit;
      mask_r      <= cfg.priority_allow_mask[in_priority_req];
      prio0_r     <= (in_priority_req == 3'd0);
      alarm_hit_r <= alarm_hit;
    end
  end

  // Refill, admission decision and core word sum.
  always_comb begin
    refill_sum = SUM_W'(tok_r) + SUM_W'(prod_r);
    tok_ref    = tok_r;
    if (it_steal_r && (elapsed_r != '0)) begin
      tok_ref = (refill_sum > SUM_W'(cfg.token_capacity)) ? cfg.token_capacity
                                                          : refill_sum[TOK_W-1:0];
    end
    priority if (!it_steal_r) admit = 1'b0;
    else if (hard_r)          admit = prio0_r && mask_r;
    else if (soft_r)          admit = mask_r && (tok_ref != '0);
    else                      admit = 1'b1;
    in_range = ({1'b0, it_addr_r} < DEPTH_LIM);
    word_sum = mem_rdata + it_inc_r;
    wlen_inc = {1'b0, wlen_r} + (cst_pkg::WIN_W + 1)'(1);
  end

  // Next values of the scalar state on execute.
  always_comb begin
    tok_nxt      = tok_r;
    elapsed_nxt  = elapsed_r;
    wlen_nxt     = wlen_r;
    wsc_nxt      = wsc_r;
    acc_tot_nxt  = acc_tot_r;
    drop_tot_nxt = drop_tot_r;
    alarm_nxt    = alarm_r;
    if (ctl.exec) begin
      if (it_tick_r) begin
        elapsed_nxt = elapsed_r + 32'd1;
        if (wlen_inc > (cst_pkg::WIN_W + 1)'(cst_pkg::WIN_MAX)) begin
          wlen_nxt = wlen_inc[cst_pkg::WIN_W:1];
          wsc_nxt  = wsc_r >> 1;
        end else begin
          wlen_nxt = wlen_inc[cst_pkg::WIN_W-1:0];
        end
      end
      if (it_steal_r) begin
        tok_nxt = (admit && (tok_ref != '0)) ? tok_ref - TOK_W'(1) : tok_ref;
        if (admit) begin
          elapsed_nxt = 32'd1;
          acc_tot_nxt = acc_tot_r + 32'd1;
          wsc_nxt     = wsc_inc;
          alarm_nxt   = alarm_r | alarm_hit_r;
        end else begin
          elapsed_nxt  = '0;
          drop_tot_nxt = drop_tot_r + 32'd1;
        end
      end
    end
  end

  // Scalar state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r       <= cst_pkg::TOKEN_RESET;
      elapsed_r   <= '0;
      wlen_r      <= '0;
      wsc_r       <= '0;
      acc_tot_r   <= '0;
      drop_tot_r  <= '0;
      alarm_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tok_r       <= tok_nxt;
      elapsed_r   <= elapsed_nxt;
      wlen_r      <= wlen_nxt;
      wsc_r       <= wsc_nxt;
      acc_tot_r   <= acc_tot_nxt;
      drop_tot_r  <= drop_tot_nxt;
      alarm_r     <= alarm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register: loaded on execute, emptied when the result is taken.
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (ctl.exec) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      res_acc_r      <= admit;
      res_alarm_r    <= alarm_nxt;
      res_tok_r      <= tok_nxt;
      res_val_r      <= (admit && in_range) ? word_sum : '0;
      res_acc_tot_r  <= acc_tot_nxt;
      res_drop_tot_r <= drop_tot_nxt;
    end
  end

  // Core word write-back.
  assign mem_we    = ctl.exec && admit && in_range;
  assign mem_waddr = it_addr_r[AW-1:0];
  assign mem_wdata = word_sum;

  assign out_valid           = out_valid_r;
  assign out_accepted        = res_acc_r;
  assign out_overload_alarm  = res_alarm_r;
  assign out_tokens_left     = res_tok_r;
  assign out_counter_value   = res_val_r;
  assign out_steals_accepted = res_acc_tot_r;
  assign out_steals_dropped  = res_drop_tot_r;

endmodule

### hdl/cycle_steal_admission_throttle_top.sv
// Top level of the cycle-steal admission throttle: configuration, sequencer, RAM, datapath.
//
// Each request is either a machine tick or a cycle-steal request, and each
// produces exactly one result. After reset the block first sweeps the core
// word memory to its initial contents, one word per cycle, so in_ready stays
// low until the sweep is done (configuration writes are taken throughout).
// After that, in the accept cycle (ST_IDLE) the core word is read from the
// single-port-read RAM and the refill product and load compares are
// registered; in ST_EXEC, once the result slot is free, the bucket is
// refilled, the admission is decided, the word is written back and the
// result is registered. No new request is accepted until that is done.
// A request is accepted even while the previous result still waits, but it
// completes only in the cycle in which that result is taken, so out_ready
// low holds it back.
module cycle_steal_admission_throttle_top #(
  parameter int CORE_DEPTH = cst_pkg::CORE_DEPTH_DFLT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [cst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cst_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_action,
  input  logic [2:0]                         in_priority_req,
  input  logic [15:0]                        in_target_address,
  input  logic signed [15:0]                 in_increment,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_accepted,
  output logic                               out_overload_alarm,
  output logic [15:0]                        out_tokens_left,
  output logic [14:0]                        out_counter_value,
  output logic [31:0]                        out_steals_accepted,
  output logic [31:0]                        out_steals_dropped
);

  localparam int AW = $clog2(CORE_DEPTH);

  cst_pkg::cfg_t               cfg_r, cfg_nxt;
  cst_pkg::ctl_t               ctl;
  logic                        slot_free;
  logic [AW-1:0]               clr_addr;
  logic [cst_pkg::WORD_W-1:0]  clr_data;
  logic                        eng_we;
  logic [AW-1:0]               eng_waddr;
  logic [cst_pkg::WORD_W-1:0]  eng_wdata;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [cst_pkg::WORD_W-1:0]  ram_wdata;
  logic [cst_pkg::WORD_W-1:0]  ram_rdata;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cst_pkg::cfg_idx_e'(cfg_index))
        cst_pkg::CFG_RUN_ENABLE:   cfg_nxt.run_enable          = cfg_wdata[0];
        cst_pkg::CFG_STEAL_ENABLE: cfg_nxt.steal_enable        = cfg_wdata[0];
        cst_pkg::CFG_TOKEN_CAP:    cfg_nxt.token_capacity      = cfg_wdata;
        cst_pkg::CFG_REFILL:       cfg_nxt.refill_per_cycle    = cfg_wdata[7:0];
        cst_pkg::CFG_PRIO_MASK:    cfg_nxt.priority_allow_mask = cfg_wdata[7:0];
        cst_pkg::CFG_SOFT_LIMIT:   cfg_nxt.soft_limit_pct      = cfg_wdata[7:0];
        cst_pkg::CFG_HARD_LIMIT:   cfg_nxt.hard_limit_pct      = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= cst_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cst_ctrl #(
    .CORE_DEPTH (CORE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .slot_free (slot_free),
    .in_ready  (in_ready),
    .ctl       (ctl),
    .clr_addr  (clr_addr)
  );

  // Initial word contents for the clearing sweep: low words hold a base plus index.
  always_comb begin
    if ({1'b0, clr_addr} < (AW + 1)'(cst_pkg::INIT_WORDS)) begin
      clr_data = cst_pkg::INIT_BASE + cst_pkg::WORD_W'(clr_addr[5:0]);
    end else begin
      clr_data = '0;
    end
  end

  // RAM write port is shared by the sweep and the datapath write-back.
  assign ram_we    = ctl.clear_we || eng_we;
  assign ram_waddr = ctl.clear_we ? clr_addr : eng_waddr;
  assign ram_wdata = ctl.clear_we ? clr_data : eng_wdata;

  cst_ram #(
    .WIDTH (cst_pkg::WORD_W),
    .DEPTH (CORE_DEPTH)
  ) u_core_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.take),
    .raddr (in_target_address[AW-1:0]),
    .rdata (ram_rdata)
  );

  cst_engine #(
    .CORE_DEPTH (CORE_DEPTH)
  ) u_engine (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .cfg                 (cfg_r),
    .in_action           (in_action),
    .in_priority_req     (in_priority_req),
    .in_target_address   (in_target_address),
    .in_increment        (in_increment),
    .mem_rdata           (ram_rdata),
    .mem_we              (eng_we),
    .mem_waddr           (eng_waddr),
    .mem_wdata           (eng_wdata),
    .slot_free           (slot_free),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_accepted        (out_accepted),
    .out_overload_alarm  (out_overload_alarm),
    .out_tokens_left     (out_tokens_left),
    .out_counter_value   (out_counter_value),
    .out_steals_accepted (out_steals_accepted),
    .out_steals_dropped  (out_steals_dropped)
  );

endmodule

### hdl/cst_port_checker.sv
// Port-level checker for the admission throttle, bound to the top level.
`include "cycle_steal_admission_throttle_top_macros.svh"

module cst_port_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_accepted,
  input logic                           out_overload_alarm,
  input logic [15:0]                    out_tokens_left,
  input logic [14:0]                    out_counter_value,
  input logic [31:0]                    out_steals_accepted
);

  logic seen_alarm_r, seen_alarm_nxt;

  // Remember that a delivered result already carried the alarm.
  always_comb begin
    seen_alarm_nxt = seen_alarm_r;
    if (out_valid && out_ready && out_overload_alarm) begin
      seen_alarm_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_alarm_r <= 1'b0;
    end else begin
      seen_alarm_r <= seen_alarm_nxt;
    end
  end

  // A stalled result stays valid and keeps its token count and accepted-steal total.
  `CST_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_tokens_left) && $stable(out_steals_accepted),
    "result changed while stalled")

  // One request at a time: no request is taken right after an accepted one.
  `CST_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready,
    "request taken while the previous one executes")

  // The overload alarm is sticky across results.
  `CST_ASSERT_SAME(a_alarm_sticky, clk, rst_n, out_valid && seen_alarm_r,
    out_overload_alarm, "overload alarm dropped")

  // A result that was not admitted never reports a written word.
  `CST_ASSERT_SAME(a_no_word_on_drop, clk, rst_n, out_valid && !out_accepted,
    out_counter_value == 15'd0, "word value on a refused request")

endmodule

bind cycle_steal_admission_throttle_top cst_port_checker u_port_checker (.*);

### tb/sv/cycle_steal_admission_throttle_top_test.sv
// Self-checking testbench of the cycle-steal admission throttle: directed table, then random phases.
module cycle_steal_admission_throttle_top_test;
  import cst_pkg::*;

  localparam int CORE_DEPTH  = CORE_DEPTH_DFLT;
  localparam int N_PHASES    = 12;
  localparam int PHASE_ITEMS = 150;

  // One request as it crosses the input channel.
  typedef struct packed {
    logic               action;
    logic [2:0]         prio;
    logic [15:0]        addr;
    logic signed [15:0] incr;
  } req_t;

  // One result as it crosses the output channel.
  typedef struct packed {
    logic        accepted;
    logic        alarm;
    logic [15:0] tokens;
    logic [14:0] word_val;
    logic [31:0] n_acc;
    logic [31:0] n_drop;
  } res_t;

  // One line of the directed table: a register write or a request.
  typedef struct packed {
    logic        is_cfg;
    cfg_idx_e    reg_idx;
    logic [15:0] reg_val;
    req_t        req;
    logic        typed_exp;
    res_t        res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = 1'b0;
  logic [2:0] in_priority_req = '0;
  logic [15:0] in_target_address = '0;
  logic signed [15:0] in_increment = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_accepted;
  logic out_overload_alarm;
  logic [15:0] out_tokens_left;
  logic [14:0] out_counter_value;
  logic [31:0] out_steals_accepted;
  logic [31:0] out_steals_dropped;

  cycle_steal_admission_throttle_top #(.CORE_DEPTH(CORE_DEPTH)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_priority_req     (in_priority_req),
    .in_target_address   (in_target_address),
    .in_increment        (in_increment),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_accepted        (out_accepted),
    .out_overload_alarm  (out_overload_alarm),
    .out_tokens_left     (out_tokens_left),
    .out_counter_value   (out_counter_value),
    .out_steals_accepted (out_steals_accepted),
    .out_steals_dropped  (out_steals_dropped)
  );

  always #5 clk = ~clk;

  // Shadow of the configuration registers and of the throttle state.
  cfg_t        shadow_cfg;
  logic [15:0] bucket;
  logic [31:0] refill_mark;
  logic [31:0] cyc_total;
  logic [7:0]  win_len;
  logic [15:0] win_steals;
  logic [31:0] steals_taken;
  logic [31:0] steals_refused;
  logic        alarm_latched;
  logic [14:0] core_mem [CORE_DEPTH];

  res_t pending_results [$];
  int   mismatches = 0;
  int   results_seen = 0;

  function automatic res_t outcome(logic acc, logic alarm, logic [15:0] tok,
                                   logic [14:0] w, logic [31:0] na, logic [31:0] nd);
    res_t r;
    r = '{acc, alarm, tok, w, na, nd};
    return r;
  endfunction

  function automatic row_t req_row(logic act, logic [2:0] prio, logic [15:0] addr,
                                   logic [15:0] incr, logic typed_exp = 1'b0,
                                   res_t res = '0);
    row_t r;
    r = '0;
    r.req = '{act, prio, addr, incr};
    r.typed_exp = typed_exp;
    r.res = res;
    return r;
  endfunction

  function automatic row_t reg_row(cfg_idx_e idx, logic [15:0] val);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic string fmt_result(res_t r);
    return $sformatf("acc=%0d alarm=%0d tokens=%0d word=%0h taken=%0d refused=%0d",
                     r.accepted, r.alarm, r.tokens, r.word_val, r.n_acc, r.n_drop);
  endfunction

  // Advance the throttle state by one request and return the result it yields.
  function automatic res_t throttle_step(req_t r);
    longint unsigned elapsed;
    longint unsigned fill;
    int unsigned     load;
    logic            mask_ok;
    logic            pass;
    res_t            res;
    res = '0;
    if (r.action == ACT_TICK) begin
      if (shadow_cfg.run_enable) begin
        win_len = win_len + 8'd1;
        if (win_len > WIN_MAX) begin
          win_len = win_len / 2;
          win_steals = win_steals / 2;
        end
        cyc_total = cyc_total + 32'd1;
      end
    end else if (shadow_cfg.run_enable && shadow_cfg.steal_enable) begin
      // Top up the bucket for the cycles that went by since the last refill.
      if (cyc_total != refill_mark) begin
        elapsed = 32'(cyc_total - refill_mark);
        fill = bucket;
        fill += elapsed * shadow_cfg.refill_per_cycle;
        if (fill > shadow_cfg.token_capacity) fill = shadow_cfg.token_capacity;
        bucket = fill[15:0];
        refill_mark = cyc_total;
      end
      load = 0;
      if (win_len != 0) load = (32'(win_steals) * PCT_SCALE) / win_len;
      mask_ok = shadow_cfg.priority_allow_mask[r.prio];
      if (load >= shadow_cfg.hard_limit_pct) pass = (r.prio == 3'd0) && mask_ok;
      else if (load >= shadow_cfg.soft_limit_pct) pass = mask_ok && (bucket != 0);
      else pass = 1'b1;
      if (!pass) begin
        steals_refused = steals_refused + 32'd1;
      end else begin
        if (bucket != 0) bucket = bucket - 16'd1;
        res.accepted = 1'b1;
        if (r.addr < CORE_DEPTH) begin
          core_mem[r.addr] = core_mem[r.addr] + r.incr[14:0];
          res.word_val = core_mem[r.addr];
        end
        steals_taken = steals_taken + 32'd1;
        if (win_steals != 16'hFFFF) win_steals = win_steals + 16'd1;
        cyc_total = cyc_total + 32'd1;
        if (win_len > ALARM_MIN_WIN && (32'(win_steals) * PCT_SCALE) / win_len > ALARM_PCT)
          alarm_latched = 1'b1;
      end
    end
    res.alarm = alarm_latched;
    res.tokens = bucket;
    res.n_acc = steals_taken;
    res.n_drop = steals_refused;
    return res;
  endfunction

  function automatic logic [7:0] pick_limit();
    case ($urandom_range(0, 4))
      0: return 8'd0;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 120));
    endcase
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    s.run_enable = ($urandom_range(0, 7) != 0);
    s.steal_enable = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 4))
      0: s.token_capacity = '0;
      1: s.token_capacity = '1;
      2: s.token_capacity = 16'($urandom_range(1, 8));
      default: s.token_capacity = 16'($urandom_range(1, 64));
    endcase
    case ($urandom_range(0, 4))
      0: s.refill_per_cycle = '0;
      1: s.refill_per_cycle = '1;
      default: s.refill_per_cycle = 8'($urandom_range(0, 6));
    endcase
    case ($urandom_range(0, 4))
      0: s.priority_allow_mask = '0;
      1: s.priority_allow_mask = '1;
      default: s.priority_allow_mask = 8'($urandom);
    endcase
    s.soft_limit_pct = pick_limit();
    s.hard_limit_pct = pick_limit();
    return s;
  endfunction

  // Steals favor priority zero and the preloaded low words of the core memory.
  function automatic req_t random_request(int tick_pct);
    req_t r;
    r.action = ($urandom_range(0, 99) < tick_pct) ? ACT_TICK : ACT_STEAL;
    r.prio = ($urandom_range(0, 2) == 0) ? 3'd0 : 3'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: r.addr = 16'($urandom_range(0, INIT_WORDS - 1));
      5, 6, 7: r.addr = 16'($urandom_range(0, CORE_DEPTH - 1));
      8: r.addr = 16'($urandom_range(CORE_DEPTH, 16'hFFFF));
      default: r.addr = 16'($urandom);
    endcase
    r.incr = 16'($urandom);
    return r;
  endfunction

  // Write one register; the caller lowers the write enable afterwards.
  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_RUN_ENABLE:   shadow_cfg.run_enable = val[0];
      CFG_STEAL_ENABLE: shadow_cfg.steal_enable = val[0];
      CFG_TOKEN_CAP:    shadow_cfg.token_capacity = val;
      CFG_REFILL:       shadow_cfg.refill_per_cycle = val[7:0];
      CFG_PRIO_MASK:    shadow_cfg.priority_allow_mask = val[7:0];
      CFG_SOFT_LIMIT:   shadow_cfg.soft_limit_pct = val[7:0];
      CFG_HARD_LIMIT:   shadow_cfg.hard_limit_pct = val[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(cfg_t s);
    write_reg(CFG_RUN_ENABLE, 16'(s.run_enable));
    write_reg(CFG_STEAL_ENABLE, 16'(s.steal_enable));
    write_reg(CFG_TOKEN_CAP, s.token_capacity);
    write_reg(CFG_REFILL, 16'(s.refill_per_cycle));
    write_reg(CFG_PRIO_MASK, 16'(s.priority_allow_mask));
    write_reg(CFG_SOFT_LIMIT, 16'(s.soft_limit_pct));
    write_reg(CFG_HARD_LIMIT, 16'(s.hard_limit_pct));
    cfg_we <= 1'b0;
  endtask

  // Hold off new requests until every outstanding result has been taken.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Present one request after a gap and return at the edge that takes it.
  task automatic send_request(req_t r, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= r.action;
    in_priority_req <= r.prio;
    in_target_address <= r.addr;
    in_increment <= r.incr;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // Result side: check every handshake and stall in bursts of random length.
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  logic        steady = 1'b0;

  always @(posedge clk) begin
    res_t got;
    res_t want;
    got = '{out_accepted, out_overload_alarm, out_tokens_left, out_counter_value,
            out_steals_accepted, out_steals_dropped};
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing expected: %s", results_seen,
                   fmt_result(got));
      end else begin
        want = pending_results.pop_front();
        if (got.accepted !== want.accepted || got.alarm !== want.alarm ||
            got.tokens !== want.tokens || got.word_val !== want.word_val ||
            got.n_acc !== want.n_acc || got.n_drop !== want.n_drop) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: expected %s, got %s", results_seen,
                     fmt_result(want), fmt_result(got));
        end
      end
      if (mode_left == 0) begin
        steady = ($urandom_range(0, 2) == 0);
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      hold_left = steady ? 0 : $urandom_range(0, 10);
    end else if (hold_left != 0) begin
      hold_left--;
    end
    out_ready <= (hold_left == 0);
  end

  initial begin
    #4000000;
    $display("FAIL cycle_steal_admission_throttle_top");
    $finish;
  end

  initial begin
    row_t plan [$];
    req_t r;
    res_t predicted;
    cfg_t settings;
    int   tick_pct;
    int   gap_max;
    int   counted;
    int   sent;

    // Shadow state as it stands after reset.
    shadow_cfg = CFG_RESET;
    bucket = TOKEN_RESET;
    refill_mark = '0;
    cyc_total = '0;
    win_len = '0;
    win_steals = '0;
    steals_taken = '0;
    steals_refused = '0;
    alarm_latched = 1'b0;
    for (int i = 0; i < CORE_DEPTH; i++)
      core_mem[i] = (i < INIT_WORDS) ? INIT_BASE + 15'(i) : '0;

    // Directed requests; rows with a typed result follow directly from reset values.
    plan = '{
      req_row(ACT_TICK, 3'd7, 16'hFFFF, 16'h7FFF, 1'b1, outcome(0, 0, 32, 15'h0, 0, 0)),
      req_row(ACT_STEAL, 3'd0, 16'd0, 16'h0001, 1'b1, outcome(1, 0, 31, 15'h1001, 1, 0)),
      req_row(ACT_STEAL, 3'd7, 16'd63, 16'hFFFF, 1'b1, outcome(0, 0, 32, 15'h0, 1, 1)),
      req_row(ACT_STEAL, 3'd0, 16'd63, 16'h8000, 1'b1, outcome(1, 0, 31, 15'h103F, 2, 1)),
      req_row(ACT_STEAL, 3'd0, 16'd2047, 16'h7FFF, 1'b1, outcome(1, 0, 31, 15'h7FFF, 3, 1)),
      req_row(ACT_STEAL, 3'd0, 16'd2048, 16'h0005, 1'b1, outcome(1, 0, 31, 15'h0, 4, 1)),
      req_row(ACT_STEAL, 3'd0, 16'hFFFF, 16'hFFFF, 1'b1, outcome(1, 0, 31, 15'h0, 5, 1)),
      req_row(ACT_STEAL, 3'd5, 16'd1, 16'h0001, 1'b1, outcome(0, 0, 32, 15'h0, 5, 2)),
      reg_row(CFG_RUN_ENABLE, 16'd0),
      req_row(ACT_TICK, 3'd0, 16'd0, 16'h0000, 1'b1, outcome(0, 0, 32, 15'h0, 5, 2)),
      req_row(ACT_STEAL, 3'd0, 16'd3, 16'h0001, 1'b1, outcome(0, 0, 32, 15'h0, 5, 2)),
      reg_row(CFG_RUN_ENABLE, 16'd1),
      reg_row(CFG_STEAL_ENABLE, 16'd0),
      req_row(ACT_STEAL, 3'd0, 16'd4, 16'h0001, 1'b1, outcome(0, 0, 32, 15'h0, 5, 2)),
      req_row(ACT_TICK, 3'd1, 16'd4, 16'h0001, 1'b1, outcome(0, 0, 32, 15'h0, 5, 2)),
      reg_row(CFG_STEAL_ENABLE, 16'd1),
      reg_row(CFG_TOKEN_CAP, 16'd0),
      req_row(ACT_STEAL, 3'd0, 16'd2, 16'h0003, 1'b1, outcome(1, 0, 0, 15'h1005, 6, 2)),
      req_row(ACT_TICK, 3'd0, 16'd0, 16'h0000, 1'b1, outcome(0, 0, 0, 15'h0, 6, 2)),
      req_row(ACT_TICK, 3'd0, 16'd0, 16'h0000, 1'b1, outcome(0, 0, 0, 15'h0, 6, 2)),
      req_row(ACT_TICK, 3'd0, 16'd0, 16'h0000, 1'b1, outcome(0, 0, 0, 15'h0, 6, 2)),
      req_row(ACT_TICK, 3'd0, 16'd0, 16'h0000, 1'b1, outcome(0, 0, 0, 15'h0, 6, 2)),
      reg_row(CFG_HARD_LIMIT, 16'd255),
      reg_row(CFG_SOFT_LIMIT, 16'd0),
      req_row(ACT_STEAL, 3'd0, 16'd10, 16'h0007, 1'b1, outcome(0, 0, 0, 15'h0, 6, 3)),
      reg_row(CFG_TOKEN_CAP, 16'hFFFF),
      reg_row(CFG_REFILL, 16'd255),
      req_row(ACT_STEAL, 3'd3, 16'd11, 16'h0002),
      req_row(ACT_TICK, 3'd2, 16'h1234, 16'h5A5A),
      req_row(ACT_STEAL, 3'd5, 16'd64, 16'h4000),
      reg_row(CFG_PRIO_MASK, 16'h0000),
      reg_row(CFG_HARD_LIMIT, 16'd0),
      req_row(ACT_STEAL, 3'd0, 16'd12, 16'h0001),
      reg_row(CFG_PRIO_MASK, 16'h00FF),
      req_row(ACT_STEAL, 3'd0, 16'd13, 16'hFFFE),
      req_row(ACT_STEAL, 3'd1, 16'd14, 16'h0001),
      req_row(ACT_STEAL, 3'd6, 16'h0800, 16'h0001)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_all_results();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
        cfg_we <= 1'b0;
      end else begin
        send_request(plan[i].req, $urandom_range(0, 10));
        predicted = throttle_step(plan[i].req);
        pending_results.push_back(plan[i].typed_exp ? plan[i].res : predicted);
      end
    end

    // Random phases, each under its own settings and its own tick-to-steal mix.
    for (int phase = 0; phase < N_PHASES; phase++) begin
      wait_all_results();
      settings = random_settings();
      if (phase == 0) begin
        settings.run_enable = 1'b1;
        settings.steal_enable = 1'b1;
      end
      apply_settings(settings);
      tick_pct = $urandom_range(20, 80);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      counted = 0;
      sent = 0;
      while (counted < PHASE_ITEMS && (shadow_cfg.run_enable || sent < 30)) begin
        r = random_request(tick_pct);
        if (sent == PHASE_ITEMS / 2 && phase % 4 == 1) wait_all_results();
        send_request(r, $urandom_range(0, gap_max));
        pending_results.push_back(throttle_step(r));
        sent++;
        // Requests that the stopped or steal-disabled block ignores do not count.
        if (shadow_cfg.run_enable && (r.action == ACT_TICK || shadow_cfg.steal_enable))
          counted++;
      end
    end

    wait_all_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS cycle_steal_admission_throttle_top");
    end else begin
      $display("FAIL cycle_steal_admission_throttle_top");
    end
    $finish;
  end

endmodule
